// ----- rtl/core/lhp_pkg.sv -----
// shared types, constants and bucket functions for the latency histogram
`default_nettype none

package lhp_pkg;

  localparam int DEF_BUCKET_COUNT = 256;
  localparam int SUBS_PER_OCTAVE  = 4;
  localparam int DATA_W           = 64;
  localparam int BIDX_W           = 8;   // full bucket code before clamping
  localparam int TGT_W            = 71;  // holds count * 99 and seen * 100
  localparam int DIV_CNT_W        = 7;

  localparam logic [1:0] ACT_RECORD = 2'd0;
  localparam logic [1:0] ACT_REPORT = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  typedef struct packed {
    logic rec_load;
    logic rec_read;
    logic rec_write;
    logic clear;
    logic rep_start;
    logic fin;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic walk_done;
    logic div_done;
  } dp_stat_t;

  // leading one plus the two bits below it, four buckets per octave
  function automatic logic [BIDX_W-1:0] pick_bucket(input logic [DATA_W-1:0] v);
    logic [BIDX_W-1:0] idx;
    idx = '0;
    if (v[1]) begin
      idx = BIDX_W'(SUBS_PER_OCTAVE);
    end
    for (int m = 2; m < DATA_W; m++) begin
      if (v[m]) begin
        idx = BIDX_W'(SUBS_PER_OCTAVE * m) + {6'b0, v[m-1], v[m-2]};
      end
    end
    return idx;
  endfunction

  function automatic logic [DATA_W-1:0] upper_of(input logic [BIDX_W-1:0] b);
    logic [5:0]  m;
    logic [3:0]  base;
    logic [5:0]  sh;
    logic [67:0] wide;
    logic [DATA_W-1:0] res;
    m    = b[7:2];
    base = 4'd5 + {2'b0, b[1:0]};
    sh   = m - 6'd2;
    wide = {64'b0, base} << sh;
    if (m < 6'd2) begin
      res = DATA_W'(1) << m;
    end else if (|wide[67:64]) begin
      res = '1;
    end else begin
      res = wide[63:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/latency_histogram_percentiles.sv -----
// latency histogram: a record loads, reads and writes its bucket in turn; a clear or an ignored code is done in idle
// report: its length is set by the bucket walk through the single memory read port,
// with the 64-step mean divider running alongside
// a report on an empty histogram skips the walk; one transaction is in work at a time
// synchronous reset clears the statistics and all bucket valid flags at once,
// so the block accepts input in the first cycle after reset
`default_nettype none

module latency_histogram_percentiles
  import lhp_pkg::*;
#(
  parameter int BUCKET_COUNT = DEF_BUCKET_COUNT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        action,
  input  wire logic [DATA_W-1:0] sample_ns,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [DATA_W-1:0] sample_count,
  output logic      [DATA_W-1:0] total_ns,
  output logic      [DATA_W-1:0] max_ns,
  output logic      [DATA_W-1:0] mean_ns,
  output logic      [DATA_W-1:0] p50_ns,
  output logic      [DATA_W-1:0] p95_ns,
  output logic      [DATA_W-1:0] p99_ns
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lhp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  lhp_dp #(
    .BUCKET_COUNT (BUCKET_COUNT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .sample_ns    (sample_ns),
    .sample_count (sample_count),
    .total_ns     (total_ns),
    .max_ns       (max_ns),
    .mean_ns      (mean_ns),
    .p50_ns       (p50_ns),
    .p95_ns       (p95_ns),
    .p99_ns       (p99_ns)
  );

  a_pct_capped: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (p50_ns <= max_ns && p95_ns <= max_ns && p99_ns <= max_ns))
    else $error("percentile above maximum");

  a_pct_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (p50_ns <= p95_ns && p95_ns <= p99_ns))
    else $error("percentiles out of order");

  a_rec_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action == ACT_RECORD) |=> !in_ready)
    else $error("input taken during bucket update");

  a_mean_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sample_count != '0) |-> mean_ns <= total_ns)
    else $error("mean above total");

endmodule

`default_nettype wire

// ----- rtl/core/lhp_div.sv -----
// iterative restoring divider for the mean, one quotient bit per cycle
`default_nettype none

module lhp_div
  import lhp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [DATA_W-1:0] divisor,
  output logic      [DATA_W-1:0] quotient,
  output logic                   busy
);

  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    den;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DATA_W:0]      rem_sh;
  logic [DATA_W:0]      diff;

  assign rem_sh = {rem, quotient[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DATA_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      den      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!diff[DATA_W]) begin
        rem      <= diff[DATA_W-1:0];
        quotient <= {quotient[DATA_W-2:0], 1'b1};
      end else begin
        rem      <= rem_sh[DATA_W-1:0];
        quotient <= {quotient[DATA_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lhp_dp.sv -----
// datapath: statistics registers, bucket memory, percentile walk and result registers
`default_nettype none

module lhp_dp
  import lhp_pkg::*;
#(
  parameter int BUCKET_COUNT = DEF_BUCKET_COUNT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dp_cmd_t           cmd,
  output dp_stat_t               stat,
  input  wire logic [DATA_W-1:0] sample_ns,
  output logic      [DATA_W-1:0] sample_count,
  output logic      [DATA_W-1:0] total_ns,
  output logic      [DATA_W-1:0] max_ns,
  output logic      [DATA_W-1:0] mean_ns,
  output logic      [DATA_W-1:0] p50_ns,
  output logic      [DATA_W-1:0] p95_ns,
  output logic      [DATA_W-1:0] p99_ns
);

  localparam int IDX_W = $clog2(BUCKET_COUNT);
  localparam logic [BIDX_W-1:0] LAST_B = BIDX_W'(BUCKET_COUNT - 1);

  logic [DATA_W-1:0] tally, dsum, dmax;
  logic [DATA_W-1:0] v_in, vq;
  logic [BIDX_W-1:0] bfull;
  logic [IDX_W-1:0]  bidx, idxq;

  logic [DATA_W-1:0]       mem [BUCKET_COUNT];
  logic [BUCKET_COUNT-1:0] bvalid;
  logic [DATA_W-1:0]       rdata;
  logic                    rvld;
  logic [IDX_W-1:0]        rd_addr;

  logic              issuing, walk_busy;
  logic [IDX_W-1:0]  waddr;
  logic              rv, r_last;
  logic [IDX_W-1:0]  r_idx;
  logic              sv, s_last;
  logic [IDX_W-1:0]  s_idx;
  logic              cv, c_last;
  logic [IDX_W-1:0]  c_idx;
  logic [DATA_W-1:0] seen;
  logic [TGT_W-1:0]  s100;
  logic [TGT_W-1:0]  tgt   [3];
  logic [2:0]        found;
  logic [IDX_W-1:0]  pidx  [3];
  logic [TGT_W-1:0]  n_w;
  logic [DATA_W-1:0] quo;
  logic              div_busy;
  logic [DATA_W-1:0] pct   [3];

  assign v_in  = sample_ns[DATA_W-1] ? '0 : sample_ns;
  assign bfull = pick_bucket(vq);
  assign bidx  = (bfull > LAST_B) ? IDX_W'(LAST_B) : bfull[IDX_W-1:0];
  assign rd_addr = issuing ? waddr : bidx;
  assign n_w   = TGT_W'(tally);

  assign stat.cnt_zero  = (tally == '0);
  assign stat.walk_done = !walk_busy;
  assign stat.div_done  = !div_busy;

  // running statistics
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      tally <= '0;
      dsum  <= '0;
      dmax  <= '0;
    end else if (cmd.rec_load) begin
      tally <= tally + 1'b1;
      dsum  <= dsum + v_in;
      if (v_in > dmax) begin
        dmax <= v_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rec_load) begin
      vq <= v_in;
    end
    if (cmd.rec_read) begin
      idxq <= bidx;
    end
  end

  // bucket memory, an entry without its valid flag reads as zero
  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (cmd.rec_write) begin
      mem[idxq] <= (rvld ? rdata : '0) + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      bvalid <= '0;
      rvld   <= 1'b0;
    end else begin
      rvld <= bvalid[rd_addr];
      if (cmd.rec_write) begin
        bvalid[idxq] <= 1'b1;
      end
    end
  end

  // cumulative walk: read, accumulate, scale by 100, compare with count * k
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing   <= 1'b0;
      walk_busy <= 1'b0;
      rv        <= 1'b0;
      sv        <= 1'b0;
      cv        <= 1'b0;
      found     <= '0;
    end else if (cmd.rep_start) begin
      issuing   <= 1'b1;
      walk_busy <= 1'b1;
      found     <= '0;
    end else begin
      rv <= issuing;
      sv <= rv;
      cv <= sv;
      if (issuing && waddr == IDX_W'(BUCKET_COUNT - 1)) begin
        issuing <= 1'b0;
      end
      if (cv) begin
        for (int j = 0; j < 3; j++) begin
          if (!found[j] && s100 >= tgt[j]) begin
            found[j] <= 1'b1;
          end
        end
        if (c_last) begin
          walk_busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rep_start) begin
      waddr  <= '0;
      seen   <= '0;
      tgt[0] <= (n_w << 5) + (n_w << 4) + (n_w << 1);
      tgt[1] <= (n_w << 6) + (n_w << 5) - n_w;
      tgt[2] <= (n_w << 6) + (n_w << 5) + (n_w << 1) + n_w;
    end else begin
      if (issuing) begin
        waddr <= waddr + 1'b1;
      end
      if (rv) begin
        seen <= seen + (rvld ? rdata : '0);
      end
      if (sv) begin
        s100 <= (TGT_W'(seen) << 6) + (TGT_W'(seen) << 5) + (TGT_W'(seen) << 2);
      end
      if (cv) begin
        for (int j = 0; j < 3; j++) begin
          if (!found[j] && s100 >= tgt[j]) begin
            pidx[j] <= c_idx;
          end
        end
      end
    end
    r_idx  <= waddr;
    r_last <= (waddr == IDX_W'(BUCKET_COUNT - 1));
    s_idx  <= r_idx;
    s_last <= r_last;
    c_idx  <= s_idx;
    c_last <= s_last;
  end

  lhp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.rep_start),
    .dividend (dsum),
    .divisor  (tally),
    .quotient (quo),
    .busy     (div_busy)
  );

  // bucket upper bound capped at the maximum, maximum when never reached
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      pct[j] = dmax;
      if (found[j] && upper_of(BIDX_W'(pidx[j])) < dmax) begin
        pct[j] = upper_of(BIDX_W'(pidx[j]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      sample_count <= tally;
      total_ns     <= dsum;
      max_ns       <= dmax;
      mean_ns      <= stat.cnt_zero ? '0 : quo;
      p50_ns       <= stat.cnt_zero ? '0 : pct[0];
      p95_ns       <= stat.cnt_zero ? '0 : pct[1];
      p99_ns       <= stat.cnt_zero ? '0 : pct[2];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lhp_ctrl.sv -----
// controller: transaction handshakes and sequencing of record, clear and report
`default_nettype none

module lhp_ctrl
  import lhp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] action,
  output logic            out_valid,
  input  wire logic       out_ready,
  output dp_cmd_t         cmd,
  input  wire dp_stat_t   stat
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RIDX = 5'b00010,
    S_RWR  = 5'b00100,
    S_WALK = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   acc;

  assign in_ready = (state == S_IDLE);
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (action)
            ACT_RECORD: begin
              cmd.rec_load = 1'b1;
              state_next   = S_RIDX;
            end
            ACT_REPORT: begin
              if (stat.cnt_zero) begin
                state_next = S_FIN;
              end else begin
                cmd.rep_start = 1'b1;
                state_next    = S_WALK;
              end
            end
            ACT_CLEAR: cmd.clear = 1'b1;
            default: ;
          endcase
        end
      end
      S_RIDX: begin
        cmd.rec_read = 1'b1;
        state_next   = S_RWR;
      end
      S_RWR: begin
        cmd.rec_write = 1'b1;
        state_next    = S_IDLE;
      end
      S_WALK: begin
        if (stat.walk_done && stat.div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        // wait until the previous result has been taken
        if (!out_valid || out_ready) begin
          cmd.fin        = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ----- sim/latency_histogram_percentiles_tb.sv -----
// testbench for the latency histogram: directed table, random traffic, scoreboard
`default_nettype none

module latency_histogram_percentiles_tb
  import lhp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBKT        = DEF_BUCKET_COUNT;
  localparam int N_RANDOM    = 1150;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [63:0] cnt;
    logic [63:0] tot;
    logic [63:0] mx;
    logic [63:0] mean;
    logic [63:0] p50;
    logic [63:0] p95;
    logic [63:0] p99;
  } report_t;

  typedef struct {
    logic [1:0]  act;
    logic [63:0] val;
    bit          typed;   // expected report typed in below
    report_t     want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] action = ACT_RECORD;
  logic [63:0] sample_ns = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [63:0] sample_count, total_ns, max_ns, mean_ns, p50_ns, p95_ns, p99_ns;

  latency_histogram_percentiles i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .sample_ns(sample_ns),
    .out_valid(out_valid), .out_ready(out_ready),
    .sample_count(sample_count), .total_ns(total_ns), .max_ns(max_ns),
    .mean_ns(mean_ns), .p50_ns(p50_ns), .p95_ns(p95_ns), .p99_ns(p99_ns)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [63:0] h_count, h_sum, h_max;
  logic [63:0] h_bins [NBKT];

  report_t expected_reports[$];
  int  fail_count = 0;
  int  cycles = 0;
  bit  hold_rx = 0;

  function automatic int bin_of(logic [63:0] v);
    int m;
    int idx;
    if (v == 0) return 0;
    m = 0;
    for (int i = 63; i >= 0; i--) if (v[i]) begin m = i; break; end
    if (m < 2) idx = m * 4;
    else idx = m * 4 + int'((v >> (m - 2)) & 64'd3);
    return (idx >= NBKT) ? NBKT - 1 : idx;
  endfunction

  function automatic logic [63:0] bin_top(int b);
    int m, s;
    logic [127:0] w;
    m = b / 4;
    s = b % 4;
    if (m < 2) return 64'd1 << m;
    w = 128'(5 + s) << (m - 2);
    return (|w[127:64]) ? '1 : w[63:0];
  endfunction

  function automatic logic [63:0] pct(int k);
    logic [63:0] goal, seen, p;
    goal = (h_count / 100) * k + ((h_count % 100) * k + 99) / 100;
    seen = 0;
    p = h_max;
    for (int i = 0; i < NBKT; i++) begin
      seen += h_bins[i];
      if (seen >= goal) begin
        p = bin_top(i);
        break;
      end
    end
    return (p > h_max) ? h_max : p;
  endfunction

  task automatic histo_clear();
    h_count = 0;
    h_sum = 0;
    h_max = 0;
    foreach (h_bins[i]) h_bins[i] = 0;
  endtask

  // applies one transaction; returns 1 with the report when one is due
  function automatic bit histo_apply(logic [1:0] a, logic [63:0] raw, output report_t r);
    logic [63:0] v;
    r = '0;
    case (a)
      ACT_RECORD: begin
        v = raw[63] ? 64'd0 : raw;
        h_count++;
        h_sum += v;
        if (v > h_max) h_max = v;
        h_bins[bin_of(v)]++;
        return 0;
      end
      ACT_CLEAR: begin
        h_count = 0; h_sum = 0; h_max = 0;
        foreach (h_bins[i]) h_bins[i] = 0;
        return 0;
      end
      ACT_REPORT: begin
        r.cnt = h_count;
        r.tot = h_sum;
        r.mx = h_max;
        if (h_count != 0) begin
          r.mean = h_sum / h_count;
          r.p50 = pct(50);
          r.p95 = pct(95);
          r.p99 = pct(99);
        end
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  // valid stays high after acceptance; gap() drops it when an idle stretch follows
  task automatic send(logic [1:0] a, logic [63:0] v, bit typed, report_t tw);
    report_t r;
    bit due;
    action <= a;
    sample_ns <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    due = histo_apply(a, v, r);
    if (due) begin
      if (typed && r != tw) begin
        $display("typed row disagrees with predictor");
        fail_count++;
      end
      expected_reports.push_back(typed ? tw : r);
    end
    @(negedge clk);
  endtask

  task automatic gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n != 0) in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic [63:0] rand_val();
    logic [63:0] v;
    int sh;
    v = {$urandom(), $urandom()};
    case ($urandom_range(0, 5))
      0: return v;
      1: return 64'(v[5:0]);
      2: begin
        sh = $urandom_range(0, 63);
        return v >> sh;
      end
      3: return 64'($urandom_range(0, 5000));
      default: return 64'($urandom_range(100, 2000000));
    endcase
  endfunction

  // receiver: random stalls, one long hold-off asked by the sender
  initial begin
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        out_ready <= 1'b0;
        repeat (1500) @(negedge clk);
        hold_rx = 0;
      end else if ($urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        $display("unexpected report transaction");
        fail_count++;
      end else begin
        report_t e;
        e = expected_reports.pop_front();
        if (sample_count != e.cnt) report_mismatch("sample_count", sample_count, e.cnt);
        if (total_ns != e.tot) report_mismatch("total_ns", total_ns, e.tot);
        if (max_ns != e.mx) report_mismatch("max_ns", max_ns, e.mx);
        if (mean_ns != e.mean) report_mismatch("mean_ns", mean_ns, e.mean);
        if (p50_ns != e.p50) report_mismatch("p50_ns", p50_ns, e.p50);
        if (p95_ns != e.p95) report_mismatch("p95_ns", p95_ns, e.p95);
        if (p99_ns != e.p99) report_mismatch("p99_ns", p99_ns, e.p99);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    report_t nr;
    logic [63:0] big;
    int settle;
    histo_clear();
    big = 64'h7fff_ffff_ffff_ffff;

    // directed table
    row = '{ACT_REPORT, 64'd0, 1, '0};                            rows.push_back(row);
    row = '{ACT_RECORD, 64'd0, 0, '0};                            rows.push_back(row);
    row = '{ACT_REPORT, 64'd0, 1, '{1, 0, 0, 0, 0, 0, 0}};        rows.push_back(row);
    row = '{ACT_RECORD, 64'h8000_0000_0000_0000, 0, '0};          rows.push_back(row);
    row = '{ACT_RECORD, 64'hffff_ffff_ffff_ffff, 0, '0};          rows.push_back(row);
    row = '{ACT_RECORD, 64'd1, 0, '0};                            rows.push_back(row);
    row = '{ACT_RECORD, 64'd2, 0, '0};                            rows.push_back(row);
    row = '{ACT_RECORD, 64'd3, 0, '0};                            rows.push_back(row);
    row = '{ACT_RECORD, 64'd7, 0, '0};                            rows.push_back(row);
    row = '{ACT_UNUSED, 64'd99, 0, '0};                           rows.push_back(row);
    row = '{ACT_REPORT, 64'd0, 0, '0};                            rows.push_back(row);
    row = '{ACT_CLEAR, 64'd5, 0, '0};                             rows.push_back(row);
    row = '{ACT_REPORT, 64'd0, 1, '0};                            rows.push_back(row);
    // largest value: its bucket bound lies above it, so capped at max
    row = '{ACT_RECORD, big, 0, '0};                              rows.push_back(row);
    row = '{ACT_REPORT, 64'd0, 1, '{1, big, big, big, big, big, big}}; rows.push_back(row);
    row = '{ACT_RECORD, big, 0, '0};                              rows.push_back(row);
    row = '{ACT_RECORD, 64'd1000, 0, '0};                         rows.push_back(row);
    row = '{ACT_REPORT, 64'd0, 0, '0};                            rows.push_back(row);
    row = '{ACT_CLEAR, 64'd0, 0, '0};                             rows.push_back(row);
    row = '{ACT_RECORD, 64'd100, 0, '0};                          rows.push_back(row);
    row = '{ACT_REPORT, 64'd0, 1, '{1, 100, 100, 100, 100, 100, 100}}; rows.push_back(row);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      send(rows[i].act, rows[i].val, rows[i].typed, rows[i].want);
      gap();
    end

    // random traffic: mostly records, mixed with reports, clears and unused codes
    for (int n = 0; n < N_RANDOM; n++) begin
      int pick;
      pick = $urandom_range(0, 99);
      if (n == 300) hold_rx = 1;
      if (n >= 300 && n < 340) begin
        send(ACT_REPORT, rand_val(), 0, nr);   // fill the output while held off
      end else if (pick < 82) begin
        send(ACT_RECORD, rand_val(), 0, nr);
      end else if (pick < 95) begin
        send(ACT_REPORT, rand_val(), 0, nr);
      end else if (pick < 98) begin
        send(ACT_CLEAR, rand_val(), 0, nr);
      end else begin
        send(ACT_UNUSED, rand_val(), 0, nr);
      end
      if (n < 300 || n >= 340) gap();
    end
    send(ACT_REPORT, 64'd0, 0, nr);
    in_valid <= 1'b0;

    while (expected_reports.size() != 0) @(posedge clk);
    settle = 0;
    while (settle < 300) begin
      @(posedge clk);
      settle++;
    end
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
